@@ hw/rtl/rsfp_pkg.sv @@
// Shared constants, types and codes for the range smoother frame packer.
package rsfp_pkg;

    localparam int SENSOR_COUNT_DEF = 7;
    localparam int MM_W             = 16;
    localparam int LIMIT_W          = 11;
    localparam int CM_W             = 8;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_W       = 2;
    localparam int FIFO_CNT_W       = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1000;
    localparam logic [CM_W-1:0]    FRAME_HEAD  = 8'hFF;
    localparam logic [CM_W-1:0]    FRAME_TAIL  = 8'hAA;
    localparam logic [CM_W-1:0]    CM_MAX      = 8'hFF;

    // floor(x/5) == (x * 13108) >> 16 for every x below 2048
    localparam int                 RECIP_W     = 14;
    localparam logic [RECIP_W-1:0] RECIP_DIV5  = 14'd13108;
    localparam int                 RECIP_SHIFT = 16;
    localparam int                 PROD_W      = LIMIT_W + RECIP_W;

    typedef enum logic [1:0] {
        BYTE_HEAD,
        BYTE_DATA,
        BYTE_TAIL
    } byte_kind_t;

    typedef enum logic {
        FR_IDLE,
        FR_SEND
    } frame_state_t;

    // Write-back event from the update pipeline to the frame sequencer
    typedef struct packed {
        logic commit;     // an entry is written this cycle
        logic frame_end;  // that entry belongs to the last sensor
    } rsfp_commit_t;

endpackage

@@ hw/rtl/range_smoother_frame_packer.sv @@
// Top level of the range smoother and frame packer.
//
//  channel     | direction | handshake                  | payload
//  ------------+-----------+----------------------------+---------------------------
//  s_axis      | in        | s_axis_tvalid/tready       | tdata[15:0] = range_mm
//  m_axis      | out       | m_axis_tvalid/tready       | tdata[7:0] = frame_byte,
//              |           |                            | tlast = frame_last
//  cfg         | in        | cfg_valid/cfg_ready        | cfg_data[10:0] = range_limit_mm
//
//  A reading's entry is read from the value memory at acceptance and written
//  back in the next cycle, so readings can follow back to back. A frame
//  streams SENSOR_COUNT + 2 bytes, one per cycle while the four-entry queue
//  has room. While a frame reads the memory, a sensor's reading is held until
//  its entry has been fetched. Reset clears per-entry valid flags, so no
//  clearing pass. Output stalls hold the frame sequencer and pending readings.
module range_smoother_frame_packer #(
    parameter int SENSOR_COUNT = rsfp_pkg::SENSOR_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rsfp_pkg::MM_W-1:0]     s_axis_tdata,   // [15:0] range_mm
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rsfp_pkg::CM_W-1:0]     m_axis_tdata,   // [7:0] frame_byte
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsfp_pkg::LIMIT_W-1:0]  cfg_data        // [10:0] range_limit_mm
);
    import rsfp_pkg::*;

    localparam int SLOT_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);

    logic [LIMIT_W-1:0] limit_reg;
    logic [CM_W-1:0]    cm;
    logic [CNT_W-1:0]   progress;
    rsfp_commit_t       commit;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic [CM_W-1:0]    rd_data;

    // the user writes configuration only while idle; not enforced, the transaction is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // clamp and convert to centimetres ahead of the memory read
    rsfp_scale u_scale (
        .range_mm (s_axis_tdata),
        .limit_mm (limit_reg),
        .cm       (cm)
    );

    // read-modify-write of the per-sensor smoothed value
    rsfp_store #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SLOT_W       (SLOT_W),
        .CNT_W        (CNT_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cm     (cm),
        .progress  (progress),
        .commit    (commit),
        .rd_b_en   (rd_en),
        .rd_b_addr (rd_addr),
        .rd_b_data (rd_data)
    );

    // emit header, stored values and trailer after the last sensor's update
    rsfp_framer #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SLOT_W       (SLOT_W),
        .CNT_W        (CNT_W)
    ) u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit    (commit),
        .progress  (progress),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/rsfp_scale.sv @@
// Clamp of a millimetre reading and conversion to saturated centimetres.
module rsfp_scale (
    input  logic [rsfp_pkg::MM_W-1:0]    range_mm,
    input  logic [rsfp_pkg::LIMIT_W-1:0] limit_mm,
    output logic [rsfp_pkg::CM_W-1:0]    cm
);
    import rsfp_pkg::*;

    logic [LIMIT_W-1:0]         clamped;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-RECIP_SHIFT-1:0] cm_full;

    always_comb begin
        if (range_mm > MM_W'(limit_mm)) begin
            clamped = limit_mm;
        end else begin
            clamped = range_mm[LIMIT_W-1:0];
        end
        prod    = PROD_W'(clamped) * PROD_W'(RECIP_DIV5);
        cm_full = prod[PROD_W-1:RECIP_SHIFT];
        // saturate: limits above 1279 would exceed one byte
        if (cm_full > (PROD_W-RECIP_SHIFT)'(CM_MAX)) begin
            cm = CM_MAX;
        end else begin
            cm = cm_full[CM_W-1:0];
        end
    end

endmodule

@@ hw/rtl/rsfp_store.sv @@
// Smoothed-value memory with its read-modify-write update pipeline.
module rsfp_store #(
    parameter int SENSOR_COUNT = rsfp_pkg::SENSOR_COUNT_DEF,
    parameter int SLOT_W       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1,
    parameter int CNT_W        = $clog2(SENSOR_COUNT + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rsfp_pkg::CM_W-1:0]  in_cm,
    input  logic [CNT_W-1:0]           progress,
    output rsfp_pkg::rsfp_commit_t     commit,
    input  logic                       rd_b_en,
    input  logic [SLOT_W-1:0]          rd_b_addr,
    output logic [rsfp_pkg::CM_W-1:0]  rd_b_data
);
    import rsfp_pkg::*;

    logic [CM_W-1:0]   cm_mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] vld_reg;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              s1_vld_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [CM_W-1:0]   s1_cm_reg;
    logic              s1_last_reg;
    logic              s1_seen_reg;
    logic [CM_W-1:0]   rd_a_data_reg;
    logic [CM_W-1:0]   rd_b_data_reg;

    logic              accept;
    logic              slot_last;
    logic [CM_W-1:0]   old_cm;
    logic [CM_W:0]     sum;
    logic [CM_W-1:0]   wr_data;

    // An entry is taken only after the frame reader has fetched it. Same-entry
    // overlap of read and write-back can only arise with one sensor, where the
    // pending frame already blocks the next reading.
    assign in_ready  = CNT_W'(slot_reg) < progress;
    assign accept    = in_valid && in_ready;
    assign slot_last = slot_reg == SLOT_W'(SENSOR_COUNT - 1);

    always_comb begin
        if (slot_last) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
        end
        old_cm  = s1_seen_reg ? rd_a_data_reg : '0;
        sum     = (CM_W+1)'(old_cm) + (CM_W+1)'(s1_cm_reg);
        wr_data = sum[CM_W:1];
    end

    assign commit.commit    = s1_vld_reg;
    assign commit.frame_end = s1_last_reg;
    assign rd_b_data        = rd_b_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            s1_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end else begin
            s1_vld_reg <= accept;
            if (accept) begin
                slot_reg <= slot_next;
            end
            if (s1_vld_reg) begin
                vld_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_a_data_reg <= cm_mem[slot_reg];
            s1_seen_reg   <= vld_reg[slot_reg];
            s1_slot_reg   <= slot_reg;
            s1_cm_reg     <= in_cm;
            s1_last_reg   <= slot_last;
        end
        if (rd_b_en) begin
            rd_b_data_reg <= cm_mem[rd_b_addr];
        end
        if (s1_vld_reg) begin
            cm_mem[s1_slot_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/rsfp_framer.sv @@
// Frame sequencer: header, memory readout, trailer, into a small output queue.
module rsfp_framer #(
    parameter int SENSOR_COUNT = rsfp_pkg::SENSOR_COUNT_DEF,
    parameter int SLOT_W       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1,
    parameter int CNT_W        = $clog2(SENSOR_COUNT + 1),
    parameter int SEQ_W        = $clog2(SENSOR_COUNT + 2)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rsfp_pkg::rsfp_commit_t     commit,
    output logic [CNT_W-1:0]           progress,
    output logic                       rd_en,
    output logic [SLOT_W-1:0]          rd_addr,
    input  logic [rsfp_pkg::CM_W-1:0]  rd_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rsfp_pkg::CM_W-1:0]  out_byte,
    output logic                       out_last
);
    import rsfp_pkg::*;

    frame_state_t    state_reg, state_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic            pend_reg, pend_next;
    logic            pipe_vld_reg;
    byte_kind_t      pipe_kind_reg;

    logic [CM_W-1:0] fifo_byte_reg [FIFO_DEPTH];
    logic            fifo_last_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;

    byte_kind_t      kind;
    logic            credit_ok;
    logic            issue;
    logic            frame_req;
    logic            push, pop;
    logic [CM_W-1:0] push_byte;

    assign frame_req = commit.commit && commit.frame_end;
    assign credit_ok = (cnt_reg + FIFO_CNT_W'(pipe_vld_reg)) < FIFO_CNT_W'(FIFO_DEPTH);
    assign issue     = (state_reg == FR_SEND) && credit_ok;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (pend_reg) begin
                    state_next = FR_SEND;
                end
            end
            FR_SEND: begin
                if (issue && (seq_reg == SEQ_W'(SENSOR_COUNT + 1))) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        if (seq_reg == '0) begin
            kind = BYTE_HEAD;
        end else if (seq_reg == SEQ_W'(SENSOR_COUNT + 1)) begin
            kind = BYTE_TAIL;
        end else begin
            kind = BYTE_DATA;
        end
        rd_en   = issue && (kind == BYTE_DATA);
        rd_addr = SLOT_W'(seq_reg - 1'b1);

        seq_next = seq_reg;
        case (state_reg)
            FR_IDLE: seq_next = '0;
            FR_SEND: begin
                if (issue) begin
                    seq_next = seq_reg + 1'b1;
                end
            end
            default: seq_next = '0;
        endcase

        pend_next = pend_reg;
        if (frame_req) begin
            pend_next = 1'b1;
        end else if (state_reg == FR_IDLE) begin
            pend_next = 1'b0;
        end

        // slots already fetched for the frame in progress
        if (pend_reg || frame_req) begin
            progress = '0;
        end else if (state_reg == FR_SEND) begin
            progress = (seq_reg == '0) ? '0 : CNT_W'(seq_reg - 1'b1);
        end else begin
            progress = CNT_W'(SENSOR_COUNT);
        end
    end

    always_comb begin
        case (pipe_kind_reg)
            BYTE_HEAD: push_byte = FRAME_HEAD;
            BYTE_DATA: push_byte = rd_data;
            BYTE_TAIL: push_byte = FRAME_TAIL;
            default:   push_byte = FRAME_HEAD;
        endcase
    end

    assign push      = pipe_vld_reg;
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;
    assign out_byte  = fifo_byte_reg[rd_ptr_reg];
    assign out_last  = fifo_last_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FR_IDLE;
            seq_reg      <= '0;
            pend_reg     <= 1'b0;
            pipe_vld_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            seq_reg      <= seq_next;
            pend_reg     <= pend_next;
            pipe_vld_reg <= issue;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pipe_kind_reg <= kind;
        end
        if (push) begin
            fifo_byte_reg[wr_ptr_reg] <= push_byte;
            fifo_last_reg[wr_ptr_reg] <= pipe_kind_reg == BYTE_TAIL;
        end
    end

endmodule

@@ hw/rtl/rsfp_checker.sv @@
// Port-level assertions for the range smoother frame packer, with its bind.
module rsfp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [rsfp_pkg::CM_W-1:0]    m_axis_tdata,
    input logic                         m_axis_tlast
);
    import rsfp_pkg::*;

    // the trailer is the only byte marked last
    a_last_is_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == FRAME_TAIL)
        else $error("tlast on a byte other than the trailer");

    // a valid byte right after an accepted trailer is a header
    a_head_after_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast
        |=> !m_axis_tvalid || (m_axis_tdata == FRAME_HEAD && !m_axis_tlast))
        else $error("frame does not start with the header");

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind range_smoother_frame_packer rsfp_checker u_rsfp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
